// ===== design/dpb_pkg.sv =====
package dpb_pkg;

    localparam int SKIP_DEF      = 4;
    localparam int MAX_WIDTH_DEF = 4095;
    localparam int CNT_W         = 12;
    localparam int PH_W          = 4;
    localparam int NUM_W         = 34;
    localparam int QUO_W         = 17;

    typedef enum logic [2:0] {
        REG_IMAGE_WIDTH = 3'd0,
        REG_FOCAL_X     = 3'd1,
        REG_FOCAL_Y     = 3'd2,
        REG_CENTER_X    = 3'd3,
        REG_CENTER_Y    = 3'd4,
        REG_MIN_DEPTH   = 3'd5,
        REG_MAX_DEPTH   = 3'd6
    } reg_idx_t;

    typedef struct packed {
        logic [CNT_W-1:0] u;
        logic [CNT_W-1:0] v;
        logic [15:0]      depth;
        logic             valid;
        logic             last;
    } job_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_OUT
    } back_state_t;

endpackage

// ===== design/dpb_front.sv =====
module dpb_front
    import dpb_pkg::*;
#(
    parameter int SKIP      = SKIP_DEF,
    parameter int MAX_WIDTH = MAX_WIDTH_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [15:0] pixel_depth,
    input  logic        frame_end,
    input  logic [11:0] image_width,
    input  logic [15:0] min_depth,
    input  logic [15:0] max_depth,
    output logic        job_valid,
    input  logic        job_ready,
    output job_t        job
);

    logic [CNT_W-1:0] col_reg, col_next;
    logic [CNT_W-1:0] row_reg, row_next;
    logic [PH_W-1:0]  cph_reg, cph_next;
    logic [PH_W-1:0]  rph_reg, rph_next;
    logic [CNT_W-1:0] width_eff;
    logic [CNT_W:0]   col_inc;
    logic             used;
    logic             in_range;
    logic             take;

    always_comb
    begin
        width_eff = image_width;
        if (image_width > CNT_W'(MAX_WIDTH))
            width_eff = CNT_W'(MAX_WIDTH);
        if (width_eff == '0)
            width_eff = CNT_W'(1);
    end

    // column and row phases count modulo SKIP alongside the counters
    assign used = (cph_reg == '0) && (rph_reg == '0);
    assign in_range = (pixel_depth != '0) && (pixel_depth >= min_depth)
                      && (pixel_depth <= max_depth);

    // pixels that give no result drain without waiting on the queue
    assign take = used && in_range || frame_end;
    assign in_ready = take ? job_ready : 1'b1;
    assign job_valid = in_valid && take;

    assign job.u = col_reg;
    assign job.v = row_reg;
    assign job.depth = pixel_depth;
    assign job.valid = used && in_range;
    assign job.last = frame_end;

    always_comb
    begin
        col_inc = {1'b0, col_reg} + (CNT_W+1)'(1);
        col_next = col_reg;
        row_next = row_reg;
        cph_next = cph_reg;
        rph_next = rph_reg;
        if (frame_end)
        begin
            col_next = '0;
            row_next = '0;
            cph_next = '0;
            rph_next = '0;
        end
        else if (col_inc >= {1'b0, width_eff})
        begin
            col_next = '0;
            row_next = row_reg + CNT_W'(1);
            cph_next = '0;
            if (row_reg == '1 || rph_reg == PH_W'(SKIP-1))
                rph_next = '0;
            else
                rph_next = rph_reg + PH_W'(1);
        end
        else
        begin
            col_next = col_inc[CNT_W-1:0];
            if (cph_reg == PH_W'(SKIP-1))
                cph_next = '0;
            else
                cph_next = cph_reg + PH_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= '0;
            cph_reg <= '0;
            rph_reg <= '0;
        end
        else if (in_valid && in_ready)
        begin
            col_reg <= col_next;
            row_reg <= row_next;
            cph_reg <= cph_next;
            rph_reg <= rph_next;
        end
    end

endmodule

// ===== design/dpb_queue.sv =====
module dpb_queue
    import dpb_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic wr_valid,
    output logic wr_ready,
    input  job_t wr_data,
    output logic rd_valid,
    input  logic rd_ready,
    output job_t rd_data
);

    job_t       mem_reg [2];
    logic       wp_reg, rp_reg;
    logic [1:0] cnt_reg;

    assign wr_ready = cnt_reg != 2'd2;
    assign rd_valid = cnt_reg != 2'd0;
    assign rd_data  = mem_reg[rp_reg];

    always_ff @(posedge clk)
    begin
        if (wr_valid && wr_ready)
            mem_reg[wp_reg] <= wr_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            if (wr_valid && wr_ready)
                wp_reg <= ~wp_reg;
            if (rd_valid && rd_ready)
                rp_reg <= ~rp_reg;
            cnt_reg <= cnt_reg + 2'(wr_valid && wr_ready) - 2'(rd_valid && rd_ready);
        end
    end

endmodule

// ===== design/dpb_back.sv =====
module dpb_back
    import dpb_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               job_valid,
    output logic               job_ready,
    input  job_t               job,
    input  logic [15:0]        focal_x_q4,
    input  logic [15:0]        focal_y_q4,
    input  logic [15:0]        center_x_q4,
    input  logic [15:0]        center_y_q4,
    output logic               out_valid,
    input  logic               out_ready,
    output logic signed [15:0] point_x_mm,
    output logic signed [15:0] point_y_mm,
    output logic [15:0]        point_z_mm,
    output logic               point_valid,
    output logic               frame_last
);

    back_state_t state_reg, state_next;

    // two restoring dividers, one quotient bit per cycle, x and y side by side
    logic [NUM_W-1:0] nx_reg, nx_next, ny_reg, ny_next;
    logic [16:0]      rx_reg, rx_next, ry_reg, ry_next;
    logic [QUO_W-1:0] qx_reg, qx_next, qy_reg, qy_next;
    logic             sx_reg, sx_next, sy_reg, sy_next;
    logic             nzx_reg, nzx_next, nzy_reg, nzy_next;
    logic [5:0]       step_reg, step_next;
    logic [15:0]      z_reg, z_next;
    logic             pv_reg, pv_next, last_reg, last_next;
    logic [15:0]      xo_reg, xo_next, yo_reg, yo_next;

    logic signed [17:0] dx, dy;
    logic signed [34:0] px, py;
    logic [16:0]        tx, ty;
    logic [17:0]        dfx, dfy;

    function automatic logic [15:0] fin(input logic [QUO_W-1:0] q, input logic neg,
                                        input logic fz, input logic nz);
        logic [15:0] r;
        r = '0;
        if (fz)
            r = !nz ? 16'h0000 : (neg ? 16'h8000 : 16'h7FFF);
        else if (neg)
            r = (q > QUO_W'(32768)) ? 16'h8000 : 16'(-q);
        else
            r = (q > QUO_W'(32767)) ? 16'h7FFF : q[15:0];
        return r;
    endfunction

    assign dx = $signed({2'b0, job.u, 4'b0}) - $signed({2'b0, center_x_q4});
    assign dy = $signed({2'b0, job.v, 4'b0}) - $signed({2'b0, center_y_q4});
    assign px = dx * $signed({1'b0, job.depth});
    assign py = dy * $signed({1'b0, job.depth});

    always_comb
    begin
        state_next = state_reg;
        nx_next = nx_reg; ny_next = ny_reg;
        rx_next = rx_reg; ry_next = ry_reg;
        qx_next = qx_reg; qy_next = qy_reg;
        sx_next = sx_reg; sy_next = sy_reg;
        nzx_next = nzx_reg; nzy_next = nzy_reg;
        step_next = step_reg;
        z_next = z_reg; pv_next = pv_reg; last_next = last_reg;
        xo_next = xo_reg; yo_next = yo_reg;
        job_ready = 1'b0;
        tx = {rx_reg[15:0], nx_reg[NUM_W-1]};
        ty = {ry_reg[15:0], ny_reg[NUM_W-1]};
        dfx = {1'b0, tx} - {2'b0, focal_x_q4};
        dfy = {1'b0, ty} - {2'b0, focal_y_q4};
        unique case (state_reg)
            ST_IDLE:
            begin
                job_ready = 1'b1;
                if (job_valid)
                begin
                    sx_next = px[34];
                    sy_next = py[34];
                    nzx_next = px != '0;
                    nzy_next = py != '0;
                    nx_next = px[34] ? NUM_W'(-px) : px[NUM_W-1:0];
                    ny_next = py[34] ? NUM_W'(-py) : py[NUM_W-1:0];
                    rx_next = '0; ry_next = '0;
                    qx_next = '0; qy_next = '0;
                    step_next = '0;
                    z_next = job.valid ? job.depth : 16'h0000;
                    pv_next = job.valid;
                    last_next = job.last;
                    xo_next = '0; yo_next = '0;
                    state_next = job.valid ? ST_DIV : ST_OUT;
                end
            end
            ST_DIV:
            begin
                nx_next = {nx_reg[NUM_W-2:0], 1'b0};
                ny_next = {ny_reg[NUM_W-2:0], 1'b0};
                qx_next = {qx_reg[QUO_W-2:0], ~dfx[17]};
                qy_next = {qy_reg[QUO_W-2:0], ~dfy[17]};
                rx_next = dfx[17] ? tx : dfx[16:0];
                ry_next = dfy[17] ? ty : dfy[16:0];
                // quotient saturates: keep a sticky overflow bit on top
                if (qx_reg[QUO_W-1]) qx_next[QUO_W-1] = 1'b1;
                if (qy_reg[QUO_W-1]) qy_next[QUO_W-1] = 1'b1;
                step_next = step_reg + 6'd1;
                if (step_reg == 6'(NUM_W-1))
                begin
                    xo_next = fin(qx_next, sx_reg, focal_x_q4 == '0, nzx_reg);
                    yo_next = fin(qy_next, sy_reg, focal_y_q4 == '0, nzy_reg);
                    state_next = ST_OUT;
                end
            end
            ST_OUT:
            begin
                if (out_ready)
                    state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    always_ff @(posedge clk)
    begin
        nx_reg <= nx_next; ny_reg <= ny_next;
        rx_reg <= rx_next; ry_reg <= ry_next;
        qx_reg <= qx_next; qy_reg <= qy_next;
        sx_reg <= sx_next; sy_reg <= sy_next;
        nzx_reg <= nzx_next; nzy_reg <= nzy_next;
        step_reg <= step_next;
        z_reg <= z_next; pv_reg <= pv_next; last_reg <= last_next;
        xo_reg <= xo_next; yo_reg <= yo_next;
    end

    assign out_valid   = state_reg == ST_OUT;
    assign point_x_mm  = $signed(xo_reg);
    assign point_y_mm  = $signed(yo_reg);
    assign point_z_mm  = z_reg;
    assign point_valid = pv_reg;
    assign frame_last  = last_reg;

endmodule

// ===== design/depth_pixel_to_point_backprojection.sv =====
// Depth pixels are taken one per cycle while the two-entry job queue has room; pixels
// that give no result and end no frame never enter the queue and are always taken at
// once. A used pixel in range passes the back end in order: a load, the shared-step
// restoring division that produces x and y together one quotient bit a cycle, and
// the beat, presented until it is taken; no new job is taken before then. A frame
// end with no point is loaded and presented with no division. The input stalls only
// when the queue is full of results waiting on the back end.
module depth_pixel_to_point_backprojection
    import dpb_pkg::*;
#(
    parameter int SKIP      = SKIP_DEF,
    parameter int MAX_WIDTH = MAX_WIDTH_DEF
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic [2:0]         cfg_index,
    input  logic [15:0]        cfg_data,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [15:0]        pixel_depth,
    input  logic               frame_end,
    output logic               out_valid,
    input  logic               out_ready,
    output logic signed [15:0] point_x_mm,
    output logic signed [15:0] point_y_mm,
    output logic [15:0]        point_z_mm,
    output logic               point_valid,
    output logic               frame_last
);

    logic [11:0] width_reg;
    logic [15:0] fx_reg, fy_reg, cx_reg, cy_reg, min_reg, max_reg;
    logic        fq_valid, fq_ready, bq_valid, bq_ready;
    job_t        fq_job, bq_job;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg <= 12'd640;
            fx_reg <= 16'd6160;
            fy_reg <= 16'd6160;
            cx_reg <= 16'd5120;
            cy_reg <= 16'd3840;
            min_reg <= 16'd100;
            max_reg <= 16'd3000;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_IMAGE_WIDTH: width_reg <= cfg_data[11:0];
                REG_FOCAL_X:     fx_reg <= cfg_data;
                REG_FOCAL_Y:     fy_reg <= cfg_data;
                REG_CENTER_X:    cx_reg <= cfg_data;
                REG_CENTER_Y:    cy_reg <= cfg_data;
                REG_MIN_DEPTH:   min_reg <= cfg_data;
                REG_MAX_DEPTH:   max_reg <= cfg_data;
                default:         ;
            endcase
        end
    end

    dpb_front #(.SKIP(SKIP), .MAX_WIDTH(MAX_WIDTH)) u_front (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready),
        .pixel_depth(pixel_depth), .frame_end(frame_end),
        .image_width(width_reg), .min_depth(min_reg), .max_depth(max_reg),
        .job_valid(fq_valid), .job_ready(fq_ready), .job(fq_job)
    );

    dpb_queue u_queue (
        .clk(clk), .rst_n(rst_n),
        .wr_valid(fq_valid), .wr_ready(fq_ready), .wr_data(fq_job),
        .rd_valid(bq_valid), .rd_ready(bq_ready), .rd_data(bq_job)
    );

    dpb_back u_back (
        .clk(clk), .rst_n(rst_n),
        .job_valid(bq_valid), .job_ready(bq_ready), .job(bq_job),
        .focal_x_q4(fx_reg), .focal_y_q4(fy_reg),
        .center_x_q4(cx_reg), .center_y_q4(cy_reg),
        .out_valid(out_valid), .out_ready(out_ready),
        .point_x_mm(point_x_mm), .point_y_mm(point_y_mm), .point_z_mm(point_z_mm),
        .point_valid(point_valid), .frame_last(frame_last)
    );

endmodule

// ===== design/dpb_checker.sv =====
module dpb_checker
    import dpb_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        out_valid,
    input logic        out_ready,
    input logic [15:0] point_x_mm,
    input logic [15:0] point_z_mm,
    input logic        point_valid,
    input logic        frame_last
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(point_x_mm))
        else $error("result beat dropped or changed while stalled");

    a_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> point_valid || frame_last)
        else $error("empty result beat");

    a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !point_valid |-> point_z_mm == '0 && point_x_mm == '0)
        else $error("non-point beat carries coordinates");

    a_z_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && point_valid |-> point_z_mm != '0)
        else $error("point with zero depth");

endmodule

bind depth_pixel_to_point_backprojection dpb_checker u_dpb_checker (
    .clk(clk), .rst_n(rst_n), .out_valid(out_valid), .out_ready(out_ready),
    .point_x_mm(point_x_mm), .point_z_mm(point_z_mm),
    .point_valid(point_valid), .frame_last(frame_last)
);

// ===== sim/point_checker.sv =====
`timescale 1ns / 100ps

module point_checker
    import dpb_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic [2:0]         cfg_index,
    input  logic [15:0]        cfg_data,
    input  logic               in_valid,
    input  logic               in_ready,
    input  logic [15:0]        pixel_depth,
    input  logic               frame_end,
    input  logic               out_valid,
    input  logic               out_ready,
    input  logic signed [15:0] point_x_mm,
    input  logic signed [15:0] point_y_mm,
    input  logic [15:0]        point_z_mm,
    input  logic               point_valid,
    input  logic               frame_last,
    output int                 errors,
    output int                 pending,
    output int                 points_seen,
    output int                 frames_seen
);

    typedef struct packed {
        logic signed [15:0] x;
        logic signed [15:0] y;
        logic [15:0]        z;
        logic               pv;
        logic               last;
    } point_t;

    point_t      point_q[$];
    logic [11:0] width_r;
    logic [15:0] fx_r, fy_r, cx_r, cy_r, dmin_r, dmax_r;
    logic [11:0] col, row;

    function automatic logic signed [15:0] back_project(logic [11:0] pos, logic [15:0] center,
                                                       logic [15:0] focal, logic [15:0] depth);
        longint num;
        longint q;
        num = (longint'(pos) * 16 - longint'(center)) * longint'(depth);
        if (focal == 0)
            q = (num > 0) ? 32767 : ((num < 0) ? -32768 : 0);
        else
        begin
            q = num / longint'(focal);
            if (q > 32767)
                q = 32767;
            if (q < -32768)
                q = -32768;
        end
        return q[15:0];
    endfunction

    task automatic report(string what, longint got, longint want);
        $display("mismatch %0s: got %0d expected %0d at %0t", what, got, want, $realtime);
        errors++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        point_t p;
        logic [11:0] w;
        logic ok;
        if (!rst_n)
        begin
            width_r = 12'd640; fx_r = 16'd6160; fy_r = 16'd6160;
            cx_r = 16'd5120; cy_r = 16'd3840;
            dmin_r = 16'd100; dmax_r = 16'd3000; col = '0; row = '0;
            point_q.delete();
            pending = 0;
            errors = 0; points_seen = 0; frames_seen = 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (point_q.size() == 0)
                    report("unexpected beat", 1, 0);
                else
                begin
                    p = point_q.pop_front();
                    if (point_valid !== p.pv) report("point_valid", point_valid, p.pv);
                    if (frame_last !== p.last) report("frame_last", frame_last, p.last);
                    if (point_x_mm !== p.x) report("point_x_mm", point_x_mm, p.x);
                    if (point_y_mm !== p.y) report("point_y_mm", point_y_mm, p.y);
                    if (point_z_mm !== p.z) report("point_z_mm", point_z_mm, p.z);
                    points_seen += p.pv;
                    frames_seen += p.last;
                end
            end
            if (in_valid && in_ready)
            begin
                w = (width_r == 0) ? 12'd1 : width_r;
                ok = (col % SKIP_DEF == 0) && (row % SKIP_DEF == 0) && pixel_depth != 0
                     && pixel_depth >= dmin_r && pixel_depth <= dmax_r;
                p = '0;
                p.last = frame_end;
                if (ok)
                begin
                    p.x = back_project(col, cx_r, fx_r, pixel_depth);
                    p.y = back_project(row, cy_r, fy_r, pixel_depth);
                    p.z = pixel_depth;
                    p.pv = 1'b1;
                end
                if (ok || frame_end)
                    point_q.insert(point_q.size(), p);
                if (frame_end)
                begin
                    col = '0;
                    row = '0;
                end
                else if (col + 12'd1 >= w)
                begin
                    col = '0;
                    row = row + 12'd1;
                end
                else
                    col = col + 12'd1;
            end
            if (cfg_we)
            begin
                case (reg_idx_t'(cfg_index))
                    REG_IMAGE_WIDTH: width_r = cfg_data[11:0];
                    REG_FOCAL_X:     fx_r = cfg_data;
                    REG_FOCAL_Y:     fy_r = cfg_data;
                    REG_CENTER_X:    cx_r = cfg_data;
                    REG_CENTER_Y:    cy_r = cfg_data;
                    REG_MIN_DEPTH:   dmin_r = cfg_data;
                    REG_MAX_DEPTH:   dmax_r = cfg_data;
                    default: ;
                endcase
            end
            pending = point_q.size();
        end
    end

endmodule

// ===== sim/testbench.sv =====
`timescale 1ns / 100ps

module testbench;
    import dpb_pkg::*;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               cfg_we = 1'b0;
    logic [2:0]         cfg_index = '0;
    logic [15:0]        cfg_data = '0;
    logic               in_valid = 1'b0;
    logic               in_ready;
    logic [15:0]        pixel_depth = '0;
    logic               frame_end = 1'b0;
    logic               out_valid;
    logic               out_ready = 1'b0;
    logic signed [15:0] point_x_mm, point_y_mm;
    logic [15:0]        point_z_mm;
    logic               point_valid, frame_last;
    int                 errors, pending, points_seen, frames_seen;
    int                 send_idle = 29, recv_idle = 75;
    bit                 hold_off = 1'b0;
    longint             cycles = 0;
    int                 beats_sent = 0;

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    depth_pixel_to_point_backprojection dut (.*);

    point_checker checker_i (.*);

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > 3000000)
        begin
            $display("timeout with %0d beats outstanding", pending);
            $display("Test completed with failures");
            $finish;
        end
    end

    always @(negedge clk)
        out_ready <= !hold_off && ($urandom_range(99) >= recv_idle);

    // valid stays up after a beat so the next one can follow at once
    task automatic send_pixel(logic [15:0] d, logic fe);
        while (send_idle > 0 && $urandom_range(99) < send_idle)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        pixel_depth <= d;
        frame_end <= fe;
        do
            @(posedge clk);
        while (!in_ready);
        @(negedge clk);
        beats_sent++;
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (100)
            @(negedge clk);
    endtask

    task automatic write_reg(reg_idx_t idx, logic [15:0] val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(negedge clk);
    endtask

    task automatic set_camera(logic [15:0] w, logic [15:0] fx, logic [15:0] fy,
                              logic [15:0] cx, logic [15:0] cy,
                              logic [15:0] dmin, logic [15:0] dmax);
        write_reg(REG_IMAGE_WIDTH, w);
        write_reg(REG_FOCAL_X, fx);
        write_reg(REG_FOCAL_Y, fy);
        write_reg(REG_CENTER_X, cx);
        write_reg(REG_CENTER_Y, cy);
        write_reg(REG_MIN_DEPTH, dmin);
        write_reg(REG_MAX_DEPTH, dmax);
        cfg_we <= 1'b0;
    endtask

    // mostly in-range depths, with zero, extremes and out-of-range mixed in
    function automatic logic [15:0] pick_depth();
        int r;
        r = $urandom_range(99);
        if (r < 5)
            return 16'd0;
        if (r < 10)
            return 16'hffff;
        if (r < 20)
            return 16'($urandom);
        return 16'($urandom_range(50, 3500));
    endfunction

    task automatic send_frame(int w, int rows);
        for (int i = 0; i < w * rows; i++)
            send_pixel(pick_depth(), (i == w * rows - 1) || ($urandom_range(199) == 0));
    endtask

    task automatic random_phase(int count);
        int w;
        int base;
        logic [15:0] fx;
        base = beats_sent;
        while (beats_sent - base < count)
        begin
            w = $urandom_range(1, 12);
            if ($urandom_range(3) == 0)
                fx = 16'($urandom_range(16, 200));
            else
                fx = 16'($urandom_range(16, 65535));
            set_camera(16'(w), fx, 16'($urandom_range(16, 65535)),
                       16'($urandom), 16'($urandom),
                       16'($urandom_range(1, 400)), 16'($urandom_range(200, 65535)));
            repeat ($urandom_range(1, 3))
                send_frame(w, $urandom_range(1, 13));
            drain();
        end
    endtask

    initial
    begin
        repeat (9)
            @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed: reset settings, extremes and special cases
        send_pixel(16'd0, 1'b0);
        send_pixel(16'd100, 1'b0);
        send_pixel(16'd3000, 1'b0);
        send_pixel(16'd3001, 1'b0);
        send_pixel(16'd99, 1'b0);
        send_pixel(16'd500, 1'b1);
        send_pixel(16'd0, 1'b1);
        drain();
        set_camera(16'd0, 16'd16, 16'd16, 16'hffff, 16'd0, 16'd1, 16'hffff);
        send_pixel(16'hffff, 1'b0);
        send_pixel(16'hffff, 1'b0);
        send_pixel(16'd1, 1'b0);
        send_pixel(16'hffff, 1'b0);
        send_pixel(16'h8000, 1'b1);
        drain();
        set_camera(16'd4095, 16'hffff, 16'hffff, 16'd0, 16'hffff, 16'hffff, 16'd1);
        send_pixel(16'd1, 1'b0);
        send_pixel(16'hffff, 1'b1);
        drain();
        set_camera(16'd4, 16'hffff, 16'd16, 16'd32, 16'd32, 16'hffff, 16'hffff);
        for (int i = 0; i < 8; i++)
            send_pixel(16'hffff, i == 7);
        drain();

        // long receiver hold-off while the sender keeps pushing points
        set_camera(16'd1, 16'd6160, 16'd6160, 16'd5120, 16'd3840, 16'd1, 16'hffff);
        hold_off = 1'b1;
        fork
            begin
                repeat (400)
                    @(negedge clk);
                hold_off = 1'b0;
            end
            for (int i = 0; i < 6; i++)
                send_pixel(16'($urandom_range(1, 65535)), 1'b1);
        join
        drain();

        random_phase(500);
        send_idle = 75;
        recv_idle = 29;
        random_phase(500);
        send_idle = 0;
        recv_idle = 0;
        random_phase(500);
        set_camera(16'd640, 16'd6160, 16'd6160, 16'd5120, 16'd3840, 16'd100, 16'd3000);
        drain();

        $display("%0d pixels sent, %0d points and %0d frame ends checked",
                 beats_sent, points_seen, frames_seen);
        $display("widths 0..4095, zero and full-scale depths, saturation and stalls covered");
        if (errors == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
